// ===== rtl/der_pkg.sv =====
package der_pkg;

  // Longest run that one escape triple may describe.
  localparam int unsigned MAX_RUN = 255;
  // Default depth of the run queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [7:0] ESC_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] len;
    logic       last;
  } run_desc_t;

  // Up to two closed runs leave the front part in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    run_desc_t  first;
    run_desc_t  second;
  } run_push_t;

  // Number of payload bytes a closed run turns into (1 to 3).
  function automatic logic [1:0] run_bytes(input run_desc_t d);
    logic [1:0] n;
    if (d.len >= 8'd3 || d.value == ESC_BYTE) begin
      n = 2'd3;
    end else if (d.len == 8'd2) begin
      n = 2'd2;
    end else begin
      n = 2'd1;
    end
    return n;
  endfunction

  // Payload byte number idx of a closed run.
  function automatic logic [7:0] run_byte(input run_desc_t d, input logic [1:0] idx);
    logic [7:0] b;
    if (d.len >= 8'd3 || d.value == ESC_BYTE) begin
      case (idx)
        2'd0:    b = ESC_BYTE;
        2'd1:    b = (d.len >= 8'd3) ? d.value : ESC_BYTE;
        default: b = d.len;
      endcase
    end else begin
      b = d.value;
    end
    return b;
  endfunction

endpackage

// ===== rtl/der_in_if.sv =====
interface der_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/der_out_if.sv =====
interface der_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/der_front.sv =====
module der_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  der_in_if.sink             in_i,
  input  logic               space_ok_i,
  output der_pkg::run_push_t push_o
);

  logic [7:0] prev_q, prev_d;
  logic       started_q, started_d;
  logic [7:0] val_q, val_d;
  logic [7:0] len_q, len_d;

  logic              accept;
  logic [7:0]        delta;
  logic              extend;
  logic              closing;
  der_pkg::run_desc_t old_run;
  der_pkg::run_desc_t cur_run;

  assign in_i.ready = space_ok_i;
  assign accept     = in_i.valid && space_ok_i;

  assign delta   = started_q ? (in_i.in_byte - prev_q) : in_i.in_byte;
  assign extend  = (len_q != 8'd0) && (delta == val_q) && (len_q < 8'(der_pkg::MAX_RUN));
  assign closing = (len_q != 8'd0) && !extend;

  always_comb begin
    old_run.value = val_q;
    old_run.len   = len_q;
    old_run.last  = 1'b0;
    if (extend) begin
      cur_run.value = val_q;
      cur_run.len   = len_q + 8'd1;
    end else begin
      cur_run.value = delta;
      cur_run.len   = 8'd1;
    end
    cur_run.last = in_i.in_last;
  end

  always_comb begin
    push_o.cnt    = 2'd0;
    push_o.first  = old_run;
    push_o.second = cur_run;
    if (accept) begin
      if (in_i.in_last) begin
        if (closing) begin
          push_o.cnt = 2'd2;
        end else begin
          push_o.cnt   = 2'd1;
          push_o.first = cur_run;
        end
      end else if (closing) begin
        push_o.cnt = 2'd1;
      end
    end
  end

  always_comb begin
    prev_d    = prev_q;
    started_d = started_q;
    val_d     = val_q;
    len_d     = len_q;
    if (accept) begin
      if (in_i.in_last) begin
        prev_d    = 8'd0;
        started_d = 1'b0;
        val_d     = 8'd0;
        len_d     = 8'd0;
      end else begin
        prev_d    = in_i.in_byte;
        started_d = 1'b1;
        val_d     = cur_run.value;
        len_d     = cur_run.len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 8'd0;
      started_q <= 1'b0;
      val_q     <= 8'd0;
      len_q     <= 8'd0;
    end else begin
      prev_q    <= prev_d;
      started_q <= started_d;
      val_q     <= val_d;
      len_q     <= len_d;
    end
  end

endmodule

// ===== rtl/der_queue.sv =====
module der_queue #(
  parameter int unsigned DEPTH = der_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  der_pkg::run_push_t push_i,
  input  logic               pop_i,
  output der_pkg::run_desc_t head_o,
  output logic               empty_o,
  output logic               space_ok_o
);

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  der_pkg::run_desc_t mem [DEPTH];

  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] wr_next;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_next    = ptr_inc(wr_q);
  assign head_o     = mem[rd_q];
  assign empty_o    = (count_q == '0);
  // Room for the worst case of two runs closing on one beat.
  assign space_ok_o = (count_q <= CW'(DEPTH - 2));

  always_comb begin
    case (push_i.cnt)
      2'd1:    wr_d = wr_next;
      2'd2:    wr_d = ptr_inc(wr_next);
      default: wr_d = wr_q;
    endcase
    rd_d    = pop_i ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CW'(push_i.cnt) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/der_back.sv =====
module der_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  der_pkg::run_desc_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               mid_run_o,
  der_out_if.source          out_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;

  logic       load;
  logic       final_byte;
  logic [1:0] nbytes;

  assign nbytes     = der_pkg::run_bytes(head_i);
  assign final_byte = (idx_q == nbytes - 2'd1);
  assign load       = !empty_i && (!valid_q || out_o.ready);
  assign pop_o      = load && final_byte;
  assign mid_run_o  = (idx_q != 2'd0);

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.out_last = last_q;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = der_pkg::run_byte(head_i, idx_q);
      last_d  = head_i.last && final_byte;
      idx_d   = final_byte ? 2'd0 : idx_q + 2'd1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

endmodule

// ===== rtl/delta_rle_encoder_unit.sv =====
// Channel  Direction  Payload              Beat
// in_i     sink       in_byte, in_last     one raw byte
// out_o    source     out_byte, out_last   one payload byte
//
// The front part takes one raw byte per cycle while the run queue has room for two runs.
// Back part: one registered payload byte per cycle while out_o is ready, 1 to 3 per run.
// Sustained rate is one input beat per cycle unless short runs outpace the output port.
// Reset is asynchronous, active low, and clears the run state, queue pointers and valids.
// Either side may stall on its own; the queue absorbs the difference.
module delta_rle_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = der_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  der_in_if.sink    in_i,
  der_out_if.source out_o
);

  der_pkg::run_push_t push;
  der_pkg::run_desc_t head;
  logic               empty;
  logic               space_ok;
  logic               pop;
  logic               mid_run;

  der_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  der_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .space_ok_o (space_ok)
  );

  der_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .mid_run_o (mid_run),
    .out_o     (out_o)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("run queue popped while empty");

  a_double_push_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |->
      (in_i.valid && in_i.ready && in_i.in_last && push.second.last && !push.first.last))
    else $error("two runs closed outside the end of a block");

  a_mid_run_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_run |-> (!empty && (head.len >= 8'd2 || head.value == der_pkg::ESC_BYTE)))
    else $error("back part is inside a run with no multi-byte run at the head");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] payload;
    logic       mark_last;
  } payload_t;

  // Mirrors the encoder: delta against the previous raw byte, then run-length coding.
  class rle_scoreboard;
    logic [7:0]  prev_raw;
    bit          started;
    logic [7:0]  run_value;
    logic [7:0]  run_len;
    payload_t    payload_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_block();
    endfunction

    function void clear_block();
      prev_raw  = '0;
      started   = 1'b0;
      run_value = '0;
      run_len   = '0;
    endfunction

    function void push_byte(logic [7:0] b);
      payload_q.push_back('{payload: b, mark_last: 1'b0});
    endfunction

    // A run of one or two escape values must go out as a triple, or it would
    // decode as the start of an escape sequence.
    function void close_run();
      if (run_len != 0) begin
        if (run_len >= 3 || run_value == der_pkg::ESC_BYTE) begin
          push_byte(der_pkg::ESC_BYTE);
          push_byte((run_len >= 3) ? run_value : der_pkg::ESC_BYTE);
          push_byte(run_len);
        end else begin
          push_byte(run_value);
          if (run_len == 2) begin
            push_byte(run_value);
          end
        end
        run_len = '0;
      end
    endfunction

    function void take_raw_byte(logic [7:0] raw, logic last);
      logic [7:0] delta;
      delta    = started ? raw - prev_raw : raw;
      prev_raw = raw;
      started  = 1'b1;
      if (run_len != 0 && delta == run_value && run_len < der_pkg::MAX_RUN) begin
        run_len = run_len + 8'd1;
      end else begin
        close_run();
        run_value = delta;
        run_len   = 8'd1;
      end
      if (last) begin
        close_run();
        payload_q[payload_q.size() - 1].mark_last = 1'b1;
        clear_block();
      end
    endfunction

    function void check_payload_byte(logic [7:0] b, logic l);
      payload_t want;
      if (payload_q.size() == 0) begin
        $error("out_byte: no beat expected, got %02h (out_last %0b)", b, l);
        errors++;
      end else begin
        want = payload_q.pop_front();
        if (b !== want.payload) begin
          $error("out_byte: expected %02h, got %02h", want.payload, b);
          errors++;
        end
        if (l !== want.mark_last) begin
          $error("out_last: expected %0b, got %0b", want.mark_last, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_off;
  logic calm;

  logic [7:0]  gen_prev;
  bit          gen_started;
  int unsigned random_items;
  int unsigned block_items;

  rle_scoreboard encoder_model = new();

  der_in_if  in_if();
  der_out_if out_if();

  delta_rle_encoder_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: checks every accepted beat and stalls at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        encoder_model.check_payload_byte(out_if.out_byte, out_if.out_last);
      end
      out_if.ready <= !hold_off && (calm || $urandom_range(99) >= 25);
    end
  end

  // One long receiver hold-off so the run queue fills, then a window with no idling.
  initial begin
    hold_off = 1'b0;
    calm     = 1'b0;
    @(posedge rst_ni);
    repeat (10) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
    repeat (200) @(posedge clk_i);
    calm <= 1'b1;
    repeat (500) @(posedge clk_i);
    calm <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_raw(input logic [7:0] raw, input logic last);
    while (!calm && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= raw;
    in_if.in_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    encoder_model.take_raw_byte(raw, last);
  endtask

  // Picks the raw byte that produces the wanted delta.
  task automatic send_delta(input logic [7:0] delta, input logic last);
    logic [7:0] raw;
    raw         = gen_started ? gen_prev + delta : delta;
    gen_prev    = raw;
    gen_started = !last;
    send_raw(raw, last);
  endtask

  task automatic send_run(input logic [7:0] delta, input int unsigned len,
                          input logic close_block);
    for (int unsigned i = 0; i < len; i++) begin
      send_delta(delta, close_block && (i == len - 1));
    end
  endtask

  function automatic logic [7:0] pick_delta();
    logic [7:0] d;
    case ($urandom_range(7))
      0, 1:    d = der_pkg::ESC_BYTE;
      2:       d = 8'h00;
      3:       d = 8'h01;
      default: d = 8'($urandom_range(255));
    endcase
    return d;
  endfunction

  // A block is a few segments: short runs, longer runs, or plain noise.
  task automatic send_random_block(output int unsigned count);
    int unsigned segs;
    int unsigned len;
    logic [7:0]  d;
    logic        tail;
    count = 0;
    segs  = $urandom_range(1, 6);
    for (int unsigned s = 0; s < segs; s++) begin
      d    = pick_delta();
      tail = (s == segs - 1);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 4);
          send_run(d, len, tail);
        end
        4, 5: begin
          len = $urandom_range(5, 20);
          send_run(d, len, tail);
        end
        default: begin
          len = $urandom_range(1, 8);
          for (int unsigned i = 0; i < len; i++) begin
            send_delta(8'($urandom_range(255)), tail && (i == len - 1));
          end
        end
      endcase
      count += len;
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    gen_prev      = 8'h00;
    gen_started   = 1'b0;
    random_items  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-byte blocks, a lone escape and an escape pair.
    send_delta(8'h00, 1'b1);
    send_delta(der_pkg::ESC_BYTE, 1'b1);
    send_run(der_pkg::ESC_BYTE, 2, 1'b1);
    // Pair, single, lone escape mid-block, run of three, then a new value at the end.
    send_run(8'h05, 2, 1'b0);
    send_delta(8'h07, 1'b0);
    send_delta(der_pkg::ESC_BYTE, 1'b0);
    send_run(8'h09, 3, 1'b0);
    send_delta(8'h80, 1'b1);
    send_run(der_pkg::ESC_BYTE, 3, 1'b1);
    send_run(8'h00, 4, 1'b1);
    // Raw extremes with wraparound in both directions.
    send_raw(8'hFF, 1'b0);
    send_raw(8'h00, 1'b0);
    send_raw(8'hFF, 1'b1);

    // A run past the maximum length splits and leaves a short tail run.
    send_run(($urandom_range(1)) ? der_pkg::ESC_BYTE : pick_delta(),
             der_pkg::MAX_RUN + 3, 1'b1);

    while (random_items < 100) begin
      send_random_block(block_items);
      random_items += block_items;
    end
    in_if.valid <= 1'b0;

    while (encoder_model.payload_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (encoder_model.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
